/* hw/rtl/rctb_pkg.sv */
`default_nettype none

package rctb_pkg;

   localparam int MAX_NODES = 1024;
   localparam int ADDR_W    = $clog2(MAX_NODES);

   localparam logic [47:0] W48_MAX = 48'h7FFF_FFFF_FFFF;
   localparam logic [47:0] W48_MIN = 48'h8000_0000_0000;

   typedef enum logic [1:0] {
      MODE_FWD  = 2'd0,
      MODE_LOAD = 2'd1,
      MODE_ACC  = 2'd2,
      MODE_EMIT = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      ST_DONE = 2'd0,
      ST_SKIP = 2'd1,
      ST_ROOT = 2'd2
   } status_type;

   typedef struct packed {
      logic        start;
      logic [47:0] a;
      logic [31:0] b;
   } mul_req_type;

   typedef struct packed {
      logic        done;
      logic [47:0] result;
   } mul_rsp_type;

   function automatic logic [47:0] sat_add48(input logic [47:0] x, input logic [47:0] y);
      logic [48:0] s;
      s = {x[47], x} + {y[47], y};
      if (s[48] != s[47]) begin
         return s[48] ? W48_MIN : W48_MAX;
      end
      return s[47:0];
   endfunction

endpackage

`default_nettype wire

/* hw/rtl/rc_tree_beta_moment_engine.sv */
// Load, root and skipped items are answered from idle and never raise busy; accumulate
//   reads the node and parent gradients and writes their sum to the parent; forward runs
//   one multiply and emit two, on one shared 24x32 multiplier (low half, high half, final
//   step). Busy is low in the result cycle, so the next item can be accepted at the edge
//   that ends it. Reset: synchronous; afterwards the beta store is cleared, busy high.
// Results appear for one cycle on rsp_strobe; the receiver cannot stall.
`default_nettype none

module rc_tree_beta_moment_engine import rctb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [1:0]  req_mode,
   input  logic [9:0]  req_node,
   input  logic [10:0] req_parent,
   input  logic [31:0] req_resistance,
   input  logic [31:0] req_load_delay,
   input  logic [31:0] req_gradient_in,
   output logic        rsp_strobe,
   output logic [47:0] rsp_beta_out,
   output logic [47:0] rsp_res_grad,
   output logic [47:0] rsp_ldelay_grad,
   output logic [1:0]  rsp_status,
   input  logic        csr_we,
   input  logic [10:0] csr_wdata
);

   typedef enum logic [2:0] {
      S_CLEAR, S_IDLE, S_FWD, S_ACC_RD, S_ACC_ADD, S_EMIT_RD, S_EMIT_M1, S_EMIT_M2
   } state_type;

   state_type         state_ff;
   logic [ADDR_W-1:0] clr_cnt_ff;
   logic [10:0]       node_count_ff;
   logic [ADDR_W-1:0] node_ff;
   logic [ADDR_W-1:0] par_ff;
   logic [31:0]       res_ff;
   logic [31:0]       ld_ff;
   logic [47:0]       tmp_ff;
   logic [47:0]       rg_ff;
   logic              rsp_strobe_ff;
   logic [47:0]       rsp_beta_ff;
   logic [47:0]       rsp_rg_ff;
   logic [47:0]       rsp_lg_ff;
   status_type        rsp_status_ff;

   logic [10:0]       count;
   logic              accept;
   logic              in_oor;
   logic              in_root;
   mode_type          in_mode;
   logic [ADDR_W-1:0] in_node;
   logic [ADDR_W-1:0] in_par;

   logic              beta_we, beta_re;
   logic [ADDR_W-1:0] beta_waddr;
   logic [47:0]       beta_wdata, beta_rd;
   logic              grad_we, grad_re;
   logic [ADDR_W-1:0] grad_waddr, grad_raddr;
   logic [47:0]       grad_wdata, grad_rd;
   logic [47:0]       fwd_sum, acc_sum;

   mul_req_type       mul_req;
   mul_rsp_type       mul_rsp;

   assign count   = (node_count_ff > 11'(MAX_NODES)) ? 11'(MAX_NODES) : node_count_ff;
   assign busy    = (state_ff != S_IDLE);
   assign accept  = start && !busy;
   assign in_mode = mode_type'(req_mode);
   assign in_oor  = ({1'b0, req_node} >= count);
   assign in_root = req_parent[10] || (req_parent >= count);
   assign in_node = req_node[ADDR_W-1:0];
   assign in_par  = req_parent[ADDR_W-1:0];

   assign fwd_sum = sat_add48(beta_rd, mul_rsp.result);
   assign acc_sum = sat_add48(tmp_ff, grad_rd);

   assign beta_we    = (state_ff == S_CLEAR)
                    || (accept && !in_oor && in_mode == MODE_FWD && in_root)
                    || (state_ff == S_FWD && mul_rsp.done);
   assign beta_waddr = (state_ff == S_CLEAR) ? clr_cnt_ff :
                       (state_ff == S_FWD)   ? node_ff    : in_node;
   assign beta_wdata = (state_ff == S_FWD) ? fwd_sum : 48'd0;
   assign beta_re    = accept && !in_oor && in_mode == MODE_FWD && !in_root;

   assign grad_we    = (accept && !in_oor && in_mode == MODE_LOAD) || (state_ff == S_ACC_ADD);
   assign grad_waddr = (state_ff == S_ACC_ADD) ? par_ff : in_node;
   assign grad_wdata = (state_ff == S_ACC_ADD) ? acc_sum
                                               : {{16{req_gradient_in[31]}}, req_gradient_in};
   assign grad_re    = (accept && !in_oor && !in_root
                        && (in_mode == MODE_ACC || in_mode == MODE_EMIT))
                    || (state_ff == S_ACC_RD);
   assign grad_raddr = (state_ff == S_ACC_RD) ? par_ff : in_node;

   always_comb begin
      mul_req.start = (beta_re)
                   || (state_ff == S_EMIT_RD)
                   || (state_ff == S_EMIT_M1 && mul_rsp.done);
      case (state_ff)
         S_EMIT_RD: begin
            mul_req.a = grad_rd;
            mul_req.b = ld_ff;
         end
         S_EMIT_M1: begin
            mul_req.a = tmp_ff;
            mul_req.b = res_ff;
         end
         default: begin
            mul_req.a = {{16{req_resistance[31]}}, req_resistance};
            mul_req.b = req_load_delay;
         end
      endcase
   end

   rctb_ram #(.WIDTH(48), .DEPTH(MAX_NODES)) u_beta_ram (
      .clock   (clock),
      .wr_en   (beta_we),
      .wr_addr (beta_waddr),
      .wr_data (beta_wdata),
      .rd_en   (beta_re),
      .rd_addr (in_par),
      .rd_data (beta_rd)
   );

   rctb_ram #(.WIDTH(48), .DEPTH(MAX_NODES)) u_grad_ram (
      .clock   (clock),
      .wr_en   (grad_we),
      .wr_addr (grad_waddr),
      .wr_data (grad_wdata),
      .rd_en   (grad_re),
      .rd_addr (grad_raddr),
      .rd_data (grad_rd)
   );

   rctb_mulq u_mulq (
      .clock   (clock),
      .reset   (reset),
      .mul_req (mul_req),
      .mul_rsp (mul_rsp)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_CLEAR;
         clr_cnt_ff    <= '0;
         node_count_ff <= 11'(MAX_NODES);
         rsp_strobe_ff <= 1'b0;
      end else begin
         if (csr_we) begin
            node_count_ff <= csr_wdata;
         end
         rsp_strobe_ff <= 1'b0;
         case (state_ff)
            S_CLEAR: begin
               clr_cnt_ff <= clr_cnt_ff + ADDR_W'(1);
               if (clr_cnt_ff == ADDR_W'(MAX_NODES - 1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (start) begin
                  node_ff     <= in_node;
                  par_ff      <= in_par;
                  res_ff      <= req_resistance;
                  ld_ff       <= req_load_delay;
                  rsp_beta_ff <= 48'd0;
                  rsp_rg_ff   <= 48'd0;
                  rsp_lg_ff   <= 48'd0;
                  if (in_oor) begin
                     rsp_strobe_ff <= 1'b1;
                     rsp_status_ff <= ST_SKIP;
                  end else begin
                     case (in_mode)
                        MODE_LOAD: begin
                           rsp_strobe_ff <= 1'b1;
                           rsp_status_ff <= ST_DONE;
                        end
                        default: begin
                           if (in_root) begin
                              rsp_strobe_ff <= 1'b1;
                              rsp_status_ff <= ST_ROOT;
                           end else if (in_mode == MODE_FWD) begin
                              state_ff <= S_FWD;
                           end else if (in_mode == MODE_ACC) begin
                              state_ff <= S_ACC_RD;
                           end else begin
                              state_ff <= S_EMIT_RD;
                           end
                        end
                     endcase
                  end
               end
            end
            S_FWD: begin
               if (mul_rsp.done) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_beta_ff   <= fwd_sum;
                  rsp_status_ff <= ST_DONE;
                  state_ff      <= S_IDLE;
               end
            end
            S_ACC_RD: begin
               tmp_ff   <= grad_rd;
               state_ff <= S_ACC_ADD;
            end
            S_ACC_ADD: begin
               rsp_strobe_ff <= 1'b1;
               rsp_status_ff <= ST_DONE;
               state_ff      <= S_IDLE;
            end
            S_EMIT_RD: begin
               tmp_ff   <= grad_rd;
               state_ff <= S_EMIT_M1;
            end
            S_EMIT_M1: begin
               if (mul_rsp.done) begin
                  rg_ff    <= mul_rsp.result;
                  state_ff <= S_EMIT_M2;
               end
            end
            S_EMIT_M2: begin
               if (mul_rsp.done) begin
                  rsp_strobe_ff <= 1'b1;
                  rsp_rg_ff     <= rg_ff;
                  rsp_lg_ff     <= mul_rsp.result;
                  rsp_status_ff <= ST_DONE;
                  state_ff      <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_strobe      = rsp_strobe_ff;
   assign rsp_beta_out    = rsp_beta_ff;
   assign rsp_res_grad    = rsp_rg_ff;
   assign rsp_ldelay_grad = rsp_lg_ff;
   assign rsp_status      = rsp_status_ff;

endmodule

`default_nettype wire

/* hw/rtl/rctb_ram.sv */
`default_nettype none

module rctb_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* hw/rtl/rctb_mulq.sv */
`default_nettype none

module rctb_mulq import rctb_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  mul_req_type mul_req,
   output mul_rsp_type mul_rsp
);

   typedef enum logic [1:0] {M_IDLE, M_LO, M_HI, M_FIN} mstate_type;

   mstate_type  state_ff;
   logic        neg_ff;
   logic [47:0] ma_ff;
   logic [31:0] mb_ff;
   logic [55:0] lo_ff;
   logic [55:0] hi_ff;
   logic [47:0] result_ff;
   logic        done_ff;

   logic [47:0] a_mag;
   logic [31:0] b_mag;
   logic [23:0] mul_op;
   logic [55:0] prod;
   logic [63:0] q;
   logic [63:0] qn;
   logic        rem;
   logic [47:0] fin_res;

   assign a_mag  = mul_req.a[47] ? (~mul_req.a + 48'd1) : mul_req.a;
   assign b_mag  = mul_req.b[31] ? (~mul_req.b + 32'd1) : mul_req.b;
   assign mul_op = (state_ff == M_LO) ? ma_ff[23:0] : ma_ff[47:24];
   assign prod   = {32'd0, mul_op} * {24'd0, mb_ff};

   // floor of the scaled product, then saturation
   assign q   = {hi_ff, 8'd0} + {24'd0, lo_ff[55:16]};
   assign rem = |lo_ff[15:0];
   assign qn  = q + {63'd0, rem};

   always_comb begin
      if (!neg_ff) begin
         fin_res = (q > {16'd0, W48_MAX}) ? W48_MAX : q[47:0];
      end else begin
         fin_res = (qn > {16'd0, W48_MIN}) ? W48_MIN : (~qn[47:0] + 48'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= M_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         case (state_ff)
            M_IDLE: begin
               if (mul_req.start) begin
                  ma_ff    <= a_mag;
                  mb_ff    <= b_mag;
                  neg_ff   <= mul_req.a[47] ^ mul_req.b[31];
                  state_ff <= M_LO;
               end
            end
            M_LO: begin
               lo_ff    <= prod;
               state_ff <= M_HI;
            end
            M_HI: begin
               hi_ff    <= prod;
               state_ff <= M_FIN;
            end
            M_FIN: begin
               result_ff <= fin_res;
               done_ff   <= 1'b1;
               state_ff  <= M_IDLE;
            end
            default: state_ff <= M_IDLE;
         endcase
      end
   end

   assign mul_rsp.done   = done_ff;
   assign mul_rsp.result = result_ff;

endmodule

`default_nettype wire

/* hw/rtl/rctb_checker.sv */
`default_nettype none

module rctb_checker import rctb_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        start,
   input logic        busy,
   input logic        rsp_strobe,
   input logic [47:0] rsp_beta_out,
   input logic [47:0] rsp_res_grad,
   input logic [47:0] rsp_ldelay_grad,
   input logic [1:0]  rsp_status
);

   // clearing pass follows reset
   a_clear_after_reset: assert property (@(posedge clock) reset |=> busy)
      else $error("not busy after reset");

   a_item_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (rsp_strobe || busy))
      else $error("accepted item neither answered nor in progress");

   a_no_spurious: assert property (@(posedge clock) disable iff (reset)
      (!busy && !start) |=> !rsp_strobe)
      else $error("result without an item");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_status == ST_DONE || rsp_status == ST_SKIP
                      || rsp_status == ST_ROOT))
      else $error("bad status code");

   a_zero_values: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_status == ST_SKIP || rsp_status == ST_ROOT))
      |-> (rsp_beta_out == 48'd0 && rsp_res_grad == 48'd0 && rsp_ldelay_grad == 48'd0))
      else $error("skipped or root item with non-zero values");

endmodule

bind rc_tree_beta_moment_engine rctb_checker u_rctb_checker (.*);

`default_nettype wire

/* dv/tb_rc_tree_beta_moment_engine.sv */
module tb_rc_tree_beta_moment_engine;
   import rctb_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int CYCLE_LIMIT = 400_000;
   localparam int PHASE_ITEMS = 400;

   localparam logic signed [79:0] Q48_HI = 80'sh7FFF_FFFF_FFFF;
   localparam logic signed [79:0] Q48_LO = -80'sh8000_0000_0000;

   localparam logic [31:0] Q_ONE  = 32'h0001_0000;
   localparam logic [31:0] Q_TWO  = 32'h0002_0000;
   localparam logic [31:0] Q_MAXV = 32'h7FFF_FFFF;
   localparam logic [31:0] Q_MINV = 32'h8000_0000;
   localparam logic [31:0] Q_NEG1 = 32'hFFFF_FFFF;
   localparam logic [31:0] Q_ZERO = 32'h0;
   localparam logic [10:0] NO_PARENT = 11'h7FF;

   typedef struct packed {
      logic [47:0] beta;
      logic [47:0] rg;
      logic [47:0] lg;
      status_type  status;
   } moment_t;

   // is_cfg rows write node_count with the value in node
   typedef struct packed {
      bit          is_cfg;
      mode_type    mode;
      logic [10:0] node;
      logic [10:0] parent;
      logic [31:0] res;
      logic [31:0] ld;
      logic [31:0] gin;
      bit          pinned;
      logic [47:0] beta;
      status_type  status;
   } stim_row_t;

   localparam stim_row_t PLAN [30] = '{
      '{1'b0, MODE_FWD,  11'd0,    NO_PARENT, Q_ONE,  Q_ONE,  Q_ZERO, 1'b1, 48'h0, ST_ROOT},
      '{1'b0, MODE_FWD,  11'd1,    11'd0,     Q_ONE,  Q_TWO,  Q_ZERO, 1'b1, 48'h2_0000, ST_DONE},
      '{1'b0, MODE_FWD,  11'd2,    11'd1,     Q_MAXV, Q_MAXV, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd3,    11'd2,     Q_MINV, Q_MINV, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd4,    11'd3,     Q_MINV, Q_MINV, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd5,    11'd4,     Q_MINV, Q_MINV, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd6,    11'd5,     Q_MINV, Q_MAXV, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd7,    11'd1023,  Q_NEG1, 32'h1,  Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_LOAD, 11'd0,    NO_PARENT, Q_ZERO, Q_ZERO, Q_MAXV, 1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_LOAD, 11'd1,    11'd0,     Q_ZERO, Q_ZERO, Q_MINV, 1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_LOAD, 11'd2,    11'd1,     Q_ZERO, Q_ZERO, Q_NEG1, 1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_LOAD, 11'd3,    11'd2,     Q_ZERO, Q_ZERO, Q_MAXV, 1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_ACC,  11'd3,    11'd2,     Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_ACC,  11'd2,    11'd1,     Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_ACC,  11'd1,    11'd0,     Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_ACC,  11'd0,    NO_PARENT, Q_ZERO, Q_ZERO, Q_ZERO, 1'b1, 48'h0, ST_ROOT},
      '{1'b0, MODE_EMIT, 11'd0,    NO_PARENT, Q_MAXV, Q_MAXV, Q_ZERO, 1'b1, 48'h0, ST_ROOT},
      '{1'b0, MODE_EMIT, 11'd1,    11'd0,     Q_MAXV, Q_MINV, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_EMIT, 11'd3,    11'd2,     Q_MINV, Q_NEG1, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b1, MODE_FWD,  11'd3,    11'd0,     Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd5,    11'd0,     Q_ONE,  Q_ONE,  Q_ZERO, 1'b1, 48'h0, ST_SKIP},
      '{1'b0, MODE_EMIT, 11'd1023, NO_PARENT, Q_ONE,  Q_ONE,  Q_ONE,  1'b1, 48'h0, ST_SKIP},
      '{1'b0, MODE_LOAD, 11'd2,    11'd3,     Q_ZERO, Q_ZERO, Q_ONE,  1'b1, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd1,    11'd1023,  Q_MAXV, Q_MAXV, Q_ZERO, 1'b1, 48'h0, ST_ROOT},
      '{1'b0, MODE_EMIT, 11'd2,    11'd5,     Q_MAXV, Q_MAXV, Q_ZERO, 1'b1, 48'h0, ST_ROOT},
      '{1'b1, MODE_FWD,  11'd0,    11'd0,     Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_LOAD, 11'd0,    NO_PARENT, Q_ZERO, Q_ZERO, Q_ONE,  1'b1, 48'h0, ST_SKIP},
      '{1'b1, MODE_FWD,  11'd2047, 11'd0,     Q_ZERO, Q_ZERO, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_FWD,  11'd1023, 11'd6,     Q_MAXV, Q_MINV, Q_ZERO, 1'b0, 48'h0, ST_DONE},
      '{1'b0, MODE_EMIT, 11'd2,    11'd1,     Q_MAXV, Q_MAXV, Q_ZERO, 1'b0, 48'h0, ST_DONE}
   };

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic [1:0]  req_mode = '0;
   logic [9:0]  req_node = '0;
   logic [10:0] req_parent = '0;
   logic [31:0] req_resistance = '0;
   logic [31:0] req_load_delay = '0;
   logic [31:0] req_gradient_in = '0;
   logic        rsp_strobe;
   logic [47:0] rsp_beta_out;
   logic [47:0] rsp_res_grad;
   logic [47:0] rsp_ldelay_grad;
   logic [1:0]  rsp_status;
   logic        csr_we = 1'b0;
   logic [10:0] csr_wdata = '0;

   rc_tree_beta_moment_engine dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_mode        (req_mode),
      .req_node        (req_node),
      .req_parent      (req_parent),
      .req_resistance  (req_resistance),
      .req_load_delay  (req_load_delay),
      .req_gradient_in (req_gradient_in),
      .rsp_strobe      (rsp_strobe),
      .rsp_beta_out    (rsp_beta_out),
      .rsp_res_grad    (rsp_res_grad),
      .rsp_ldelay_grad (rsp_ldelay_grad),
      .rsp_status      (rsp_status),
      .csr_we          (csr_we),
      .csr_wdata       (csr_wdata)
   );

   always #1 clock = ~clock;

   // shadow of the engine
   logic signed [47:0] beta_mem [MAX_NODES];
   logic signed [47:0] grad_mem [MAX_NODES];
   bit                 grad_valid [MAX_NODES];
   logic [10:0]        node_limit = 11'd1024;

   moment_t     pending_moments [$];
   bit          pin_fixed = 1'b0;
   logic [47:0] pin_beta = '0;
   status_type  pin_status = ST_DONE;

   int idle_pct = 30;
   int sent_items = 0;
   int checked = 0;
   int errors = 0;
   int roots_seen = 0;
   int skips_seen = 0;
   int clamps = 0;
   int nets = 0;
   int settings = 0;
   int cycles = 0;

   function automatic int active_count();
      return node_limit > MAX_NODES ? MAX_NODES : int'(node_limit);
   endfunction

   function automatic logic signed [47:0] clamp48(input logic signed [79:0] v);
      if (v > Q48_HI) begin
         clamps++;
         return Q48_HI[47:0];
      end
      if (v < Q48_LO) begin
         clamps++;
         return Q48_LO[47:0];
      end
      return v[47:0];
   endfunction

   // Q product, floor on the 16 dropped bits
   function automatic logic signed [47:0] q_mul(input logic signed [47:0] a,
                                                input logic signed [31:0] b);
      logic signed [79:0] p;
      p = a * b;
      p = p >>> 16;
      return clamp48(p);
   endfunction

   function automatic moment_t predict_moment(input mode_type m, input logic [9:0] nd,
         input logic signed [10:0] par, input logic signed [31:0] r,
         input logic signed [31:0] ld, input logic signed [31:0] g);
      moment_t            o;
      int                 cnt;
      bit                 root;
      logic [9:0]         p;
      logic signed [79:0] sum;
      cnt = active_count();
      root = par < 0 || int'(par) >= cnt;
      p = par[9:0];
      o.beta = '0;
      o.rg = '0;
      o.lg = '0;
      o.status = ST_DONE;
      if (int'(nd) >= cnt) begin
         o.status = ST_SKIP;
      end else begin
         case (m)
            MODE_FWD: begin
               if (root) begin
                  beta_mem[nd] = '0;
                  o.status = ST_ROOT;
               end else begin
                  sum = beta_mem[p];
                  sum = sum + q_mul(r, ld);
                  o.beta = clamp48(sum);
                  beta_mem[nd] = o.beta;
               end
            end
            MODE_LOAD: begin
               grad_mem[nd] = g;
               grad_valid[nd] = 1'b1;
            end
            MODE_ACC: begin
               if (root) begin
                  o.status = ST_ROOT;
               end else begin
                  sum = grad_mem[p];
                  sum = sum + grad_mem[nd];
                  grad_mem[p] = clamp48(sum);
                  grad_valid[p] = 1'b1;
               end
            end
            default: begin
               if (root) begin
                  o.status = ST_ROOT;
               end else begin
                  o.rg = q_mul(grad_mem[nd], ld);
                  o.lg = q_mul(grad_mem[nd], r);
               end
            end
         endcase
      end
      return o;
   endfunction

   function automatic void check_field(input string what, input logic [47:0] want,
                                       input logic [47:0] got);
      if (want !== got) begin
         errors++;
         if (errors <= 40)
            $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want, got);
      end
   endfunction

   always @(posedge clock) begin
      moment_t want;
      cycles <= cycles + 1;
      if (cycles == CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycles,
                  pending_moments.size());
         $display("CHECK FAILED");
         $finish;
      end
      if (!reset) begin
         if (rsp_strobe) begin
            if (pending_moments.size() == 0) begin
               errors++;
               $display("%0t: result with no item outstanding, expected none, actual %h %h %h %0d",
                        $time, rsp_beta_out, rsp_res_grad, rsp_ldelay_grad, rsp_status);
            end else begin
               want = pending_moments.pop_front();
               checked++;
               if (want.status == ST_ROOT) roots_seen++;
               if (want.status == ST_SKIP) skips_seen++;
               check_field("beta_out", want.beta, rsp_beta_out);
               check_field("res_grad", want.rg, rsp_res_grad);
               check_field("ldelay_grad", want.lg, rsp_ldelay_grad);
               check_field("status", 48'(want.status), 48'(rsp_status));
            end
         end
         if (csr_we) node_limit = csr_wdata;
         if (start && !busy) begin
            want = predict_moment(mode_type'(req_mode), req_node, $signed(req_parent),
                                  req_resistance, req_load_delay, req_gradient_in);
            if (pin_fixed) begin
               want.beta = pin_beta;
               want.rg = '0;
               want.lg = '0;
               want.status = pin_status;
            end
            pending_moments.push_back(want);
         end
      end
   end

   task automatic send_item(input mode_type m, input logic [9:0] nd, input logic [10:0] par,
         input logic [31:0] r, input logic [31:0] ld, input logic [31:0] g,
         input bit pin, input logic [47:0] pbeta, input status_type pstat);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_mode <= m;
      req_node <= nd;
      req_parent <= par;
      req_resistance <= r;
      req_load_delay <= ld;
      req_gradient_in <= g;
      pin_fixed = pin;
      pin_beta = pbeta;
      pin_status = pstat;
      @(posedge clock);
      while (busy) @(posedge clock);
      sent_items++;
      @(negedge clock);
   endtask

   task automatic drain();
      start <= 1'b0;
      @(negedge clock);
      while (pending_moments.size() != 0) @(negedge clock);
   endtask

   // only while idle; busy is checked again after the results have drained
   task automatic set_count(input logic [10:0] v);
      drain();
      repeat (12) @(negedge clock);
      while (busy) @(negedge clock);
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(negedge clock);
      csr_we <= 1'b0;
      settings++;
   endtask

   function automatic logic [31:0] rand_q();
      logic [31:0] v;
      case ($urandom_range(7))
         0: begin
            case ($urandom_range(4))
               0: v = Q_MAXV;
               1: v = Q_MINV;
               2: v = Q_ZERO;
               3: v = Q_NEG1;
               default: v = Q_ONE;
            endcase
         end
         1, 2, 3: begin
            v = $urandom;
            v = {{12{v[19]}}, v[19:0]};
         end
         default: v = $urandom;
      endcase
      return v;
   endfunction

   // one net: forward parent-first, seed, accumulate child-first, emit
   task automatic run_net();
      int          cnt;
      int          k;
      int          ids [8];
      int          par [8];
      logic [31:0] r [8];
      logic [31:0] l [8];
      bit          dup;
      cnt = active_count();
      k = $urandom_range(2, cnt < 8 ? cnt : 8);
      for (int i = 0; i < k; i++) begin
         do begin
            ids[i] = $urandom_range(0, cnt - 1);
            dup = 1'b0;
            for (int j = 0; j < i; j++) if (ids[j] == ids[i]) dup = 1'b1;
         end while (dup);
         par[i] = (i == 0 || $urandom_range(9) == 0) ? -1 : ids[$urandom_range(0, i - 1)];
         r[i] = rand_q();
         l[i] = rand_q();
      end
      for (int i = 0; i < k; i++)
         send_item(MODE_FWD, ids[i][9:0], par[i][10:0], r[i], l[i], rand_q(),
                   1'b0, '0, ST_DONE);
      for (int i = 0; i < k; i++)
         send_item(MODE_LOAD, ids[i][9:0], par[i][10:0], r[i], l[i], rand_q(),
                   1'b0, '0, ST_DONE);
      for (int i = k - 1; i >= 0; i--)
         send_item(MODE_ACC, ids[i][9:0], par[i][10:0], r[i], l[i], rand_q(),
                   1'b0, '0, ST_DONE);
      for (int i = 0; i < k; i++)
         send_item(MODE_EMIT, ids[i][9:0], par[i][10:0], r[i], l[i], rand_q(),
                   1'b0, '0, ST_DONE);
      nets++;
   endtask

   // stray item; unseeded gradients are never read
   task automatic send_noise();
      int       cnt;
      int       nd;
      int       pa;
      bit       root;
      mode_type m;
      cnt = active_count();
      m = mode_type'($urandom_range(3));
      nd = (cnt > 0 && $urandom_range(99) < 85) ? $urandom_range(0, cnt - 1)
                                                : $urandom_range(0, 1023);
      case ($urandom_range(9))
         0, 1: pa = -1;
         2: pa = $urandom_range(0, 1023);
         default: pa = cnt > 0 ? $urandom_range(0, cnt - 1) : -1;
      endcase
      root = pa < 0 || pa >= cnt;
      if (nd < cnt && (m == MODE_ACC || m == MODE_EMIT) &&
          (!grad_valid[nd] || (m == MODE_ACC && !root && !grad_valid[pa])))
         m = MODE_LOAD;
      send_item(m, nd[9:0], pa[10:0], rand_q(), rand_q(), rand_q(), 1'b0, '0, ST_DONE);
   endtask

   initial begin
      int directed;
      int target;
      for (int i = 0; i < MAX_NODES; i++) begin
         beta_mem[i] = '0;
         grad_mem[i] = '0;
         grad_valid[i] = 1'b0;
      end
      repeat (3) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (PLAN[i]) begin
         if (PLAN[i].is_cfg)
            set_count(PLAN[i].node);
         else
            send_item(PLAN[i].mode, PLAN[i].node[9:0], PLAN[i].parent, PLAN[i].res,
                      PLAN[i].ld, PLAN[i].gin, PLAN[i].pinned, PLAN[i].beta,
                      PLAN[i].status);
      end
      directed = sent_items;

      for (int ph = 0; ph < 3; ph++) begin
         case (ph)
            0: set_count(11'd1024);
            1: set_count(11'($urandom_range(1, 40)));
            default: set_count(11'($urandom_range(1025, 2047)));
         endcase
         idle_pct = ph == 0 ? 30 : ph == 1 ? 74 : 0;
         target = sent_items + PHASE_ITEMS;
         while (sent_items < target) begin
            if ($urandom_range(39) == 0) drain();
            if (active_count() >= 2 && $urandom_range(99) < 80)
               run_net();
            else
               send_noise();
         end
      end

      drain();
      repeat (20) @(negedge clock);
      if (pending_moments.size() != 0) begin
         errors++;
         $display("%0t: %0d results never arrived", $time, pending_moments.size());
      end
      $display("%0d items (%0d directed) in %0d tree nets plus strays, %0d node_count writes",
               sent_items, directed, nets, settings);
      $display("%0d results: %0d roots, %0d skipped, %0d saturations predicted",
               checked, roots_seen, skips_seen, clamps);
      if (errors == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
